/* sv/csd_pkg.sv */
// Shared types, constants and helpers for the cursor shape decoder.
package csd_pkg;

  localparam int unsigned MaxCursorSideDefault = 64;
  localparam int unsigned SideW     = 7;
  localparam int unsigned IdxW      = 2 * SideW;
  localparam int unsigned OutIdxW   = 12;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [CfgIdxW-1:0] RegWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMode   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPixSz  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxes  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegShifts = 3'd5;

  localparam logic [1:0]  PixSzReset  = 2'd2;
  localparam logic [23:0] MaxesReset  = 24'hFFFFFF;
  localparam logic [14:0] ShiftsReset = 15'd4104;

  localparam logic [0:0] KindSource = 1'b0;
  localparam logic [0:0] KindMask   = 1'b1;

  typedef enum logic [1:0] {
    PH_COLOUR,
    PH_SOURCE,
    PH_MASK
  } phase_e;

  // one queued word of work: a bitmap byte to expand, or one raw pixel
  typedef struct packed {
    logic            kind;
    logic            raw;
    logic            done;
    logic [3:0]      count;
    logic [IdxW-1:0] idx;
    logic [7:0]      bits;
    logic [31:0]     fg;
    logic [31:0]     bg;
  } job_t;

  // (x / 255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

/* sv/csd_front.sv */
// Front end: config registers, byte classification and decode state, job generation.
module csd_front #(
  parameter int unsigned MaxCursorSide = csd_pkg::MaxCursorSideDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [csd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [csd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          byte_valid_i,
  output logic                          byte_ready_o,
  input  logic [7:0]                    byte_i,
  input  logic                          queue_full_i,
  output logic                          push_o,
  output csd_pkg::job_t                 job_o
);

  localparam int unsigned IdxW = csd_pkg::IdxW;

  logic [6:0]  width_q, height_q;
  logic        mode_q;
  logic [1:0]  pixsz_q;
  logic [23:0] maxes_q;
  logic [14:0] shifts_q;

  csd_pkg::phase_e phase_q, phase_d;
  logic [2:0]      ccnt_q, ccnt_d;
  logic [31:0]     fg_q, fg_d, bg_q, bg_d;
  logic [6:0]      row_q, row_d;
  logic [3:0]      rbc_q, rbc_d;
  logic [31:0]     asm_q, asm_d;
  logic [1:0]      bip_q, bip_d;
  logic [IdxW-1:0] npi_q, npi_d;

  logic            cfg_we, accept, mode_new;
  logic [6:0]      w, h;
  logic [13:0]     area;
  logic [4:0]      bpr;
  logic [6:0]      col;
  logic [3:0]      n;
  logic            last_row;
  logic [4:0]      rbc_inc;
  logic [7:0]      row_inc;
  logic [1:0]      ch;
  logic [7:0]      maxv, scaled;
  logic [4:0]      sh;
  logic [15:0]     prod;
  logic [31:0]     pix, pmask, asm_new;
  logic [2:0]      pbytes, bip_inc;
  logic            kind;

  assign cfg_ready_o  = 1'b1;
  assign byte_ready_o = !queue_full_i;
  assign cfg_we = cfg_valid_i && (cfg_index_i <= csd_pkg::RegShifts);
  assign accept = byte_valid_i && !queue_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      mode_q   <= 1'b0;
      pixsz_q  <= csd_pkg::PixSzReset;
      maxes_q  <= csd_pkg::MaxesReset;
      shifts_q <= csd_pkg::ShiftsReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        csd_pkg::RegWidth:  width_q  <= cfg_data_i[6:0];
        csd_pkg::RegHeight: height_q <= cfg_data_i[6:0];
        csd_pkg::RegMode:   mode_q   <= cfg_data_i[0];
        csd_pkg::RegPixSz:  pixsz_q  <= cfg_data_i[1:0];
        csd_pkg::RegMaxes:  maxes_q  <= cfg_data_i[23:0];
        csd_pkg::RegShifts: shifts_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign w = (int'(width_q) > int'(MaxCursorSide)) ? 7'(MaxCursorSide) : width_q;
  assign h = (int'(height_q) > int'(MaxCursorSide)) ? 7'(MaxCursorSide) : height_q;
  assign area = {7'b0, w} * {7'b0, h};
  assign bpr  = 5'(({2'b0, w} + 9'd7) >> 3);
  assign col  = {rbc_q[3:0], 3'b000};
  assign rbc_inc = {1'b0, rbc_q} + 5'd1;
  assign row_inc = {1'b0, row_q} + 8'd1;
  assign last_row = (rbc_inc == bpr) && (row_inc == {1'b0, h});

  always_comb begin
    if (col >= w) n = 4'd0;
    else if (w - col > 7'd8) n = 4'd8;
    else n = 4'(w - col);
  end

  // colour channel scaling
  assign ch = (ccnt_q >= 3'd3) ? 2'(ccnt_q - 3'd3) : ccnt_q[1:0];
  always_comb begin
    case (ch)
      2'd0:    begin maxv = maxes_q[23:16]; sh = shifts_q[14:10]; end
      2'd1:    begin maxv = maxes_q[15:8];  sh = shifts_q[9:5];   end
      default: begin maxv = maxes_q[7:0];   sh = shifts_q[4:0];   end
    endcase
  end
  assign prod   = {8'b0, byte_i} * {8'b0, maxv} + 16'd127;
  assign scaled = csd_pkg::div255(prod);
  assign pix    = {24'b0, scaled} << sh;

  always_comb begin
    case (pixsz_q)
      2'd0:    begin pbytes = 3'd1; pmask = 32'h0000_00FF; end
      2'd1:    begin pbytes = 3'd2; pmask = 32'h0000_FFFF; end
      default: begin pbytes = 3'd4; pmask = 32'hFFFF_FFFF; end
    endcase
  end
  assign asm_new = asm_q | ({24'b0, byte_i} << {bip_q, 3'b000});
  assign bip_inc = {1'b0, bip_q} + 3'd1;
  assign kind    = (phase_q == csd_pkg::PH_MASK);
  assign mode_new = (cfg_index_i == csd_pkg::RegMode) ? cfg_data_i[0] : mode_q;

  always_comb begin
    phase_d = phase_q;
    ccnt_d  = ccnt_q;
    fg_d    = fg_q;
    bg_d    = bg_q;
    row_d   = row_q;
    rbc_d   = rbc_q;
    asm_d   = asm_q;
    bip_d   = bip_q;
    npi_d   = npi_q;
    push_o  = 1'b0;
    job_o.kind  = kind;
    job_o.raw   = 1'b0;
    job_o.done  = kind && last_row;
    job_o.count = n;
    job_o.idx   = npi_q;
    job_o.bits  = byte_i;
    job_o.fg    = fg_q & pmask;
    job_o.bg    = bg_q & pmask;

    if (cfg_we) begin
      phase_d = mode_new ? csd_pkg::PH_COLOUR : csd_pkg::PH_SOURCE;
      ccnt_d = '0; fg_d = '0; bg_d = '0; row_d = '0; rbc_d = '0;
      asm_d = '0; bip_d = '0; npi_d = '0;
    end else if (accept && w != 7'd0 && h != 7'd0) begin
      if (phase_q == csd_pkg::PH_COLOUR) begin
        if (ccnt_q < 3'd3) fg_d = fg_q | pix;
        else bg_d = bg_q | pix;
        if (ccnt_q == 3'd5) begin
          ccnt_d  = '0;
          phase_d = csd_pkg::PH_SOURCE;
        end else begin
          ccnt_d = ccnt_q + 3'd1;
        end
      end else if (phase_q == csd_pkg::PH_SOURCE && !mode_q) begin
        if (bip_inc < pbytes) begin
          asm_d = asm_new;
          bip_d = bip_inc[1:0];
        end else begin
          push_o      = 1'b1;
          job_o.raw   = 1'b1;
          job_o.done  = 1'b0;
          job_o.count = 4'd1;
          job_o.fg    = asm_new & pmask;
          asm_d = '0;
          bip_d = '0;
          npi_d = npi_q + IdxW'(1);
          if (npi_q + IdxW'(1) >= area) begin
            phase_d = csd_pkg::PH_MASK;
            npi_d = '0;
            row_d = '0;
            rbc_d = '0;
          end
        end
      end else begin
        push_o = (n != 4'd0);
        npi_d  = npi_q + IdxW'(n);
        rbc_d  = rbc_inc[3:0];
        if (rbc_inc >= bpr) begin
          rbc_d = '0;
          row_d = row_inc[6:0];
          if (row_inc >= {1'b0, h}) begin
            if (!kind) begin
              phase_d = csd_pkg::PH_MASK;
              row_d = '0;
              npi_d = '0;
            end else begin
              phase_d = mode_q ? csd_pkg::PH_COLOUR : csd_pkg::PH_SOURCE;
              ccnt_d = '0; fg_d = '0; bg_d = '0; row_d = '0;
              asm_d = '0; bip_d = '0; npi_d = '0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= csd_pkg::PH_SOURCE;
      ccnt_q  <= '0;
      fg_q    <= '0;
      bg_q    <= '0;
      row_q   <= '0;
      rbc_q   <= '0;
      asm_q   <= '0;
      bip_q   <= '0;
      npi_q   <= '0;
    end else begin
      phase_q <= phase_d;
      ccnt_q  <= ccnt_d;
      fg_q    <= fg_d;
      bg_q    <= bg_d;
      row_q   <= row_d;
      rbc_q   <= rbc_d;
      asm_q   <= asm_d;
      bip_q   <= bip_d;
      npi_q   <= npi_d;
    end
  end

endmodule

/* sv/csd_queue.sv */
// Small job queue between the front and back ends.
module csd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  csd_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          not_empty_o,
  output csd_pkg::job_t head_o
);

  localparam int unsigned PtrW = csd_pkg::QueuePtrW;

  csd_pkg::job_t mem_q [csd_pkg::QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o      = (cnt_q == (PtrW+1)'(csd_pkg::QueueDepth));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrW'(1);
      if (pop_i)  rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

/* sv/csd_back.sv */
// Back end: expands queued jobs into registered result words, one per cycle unless stalled.
module csd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          not_empty_i,
  input  csd_pkg::job_t                 head_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [csd_pkg::OutIdxW-1:0]   out_idx_o,
  output logic [31:0]                   out_value_o,
  output logic                          out_kind_o,
  output logic                          out_last_o,
  output logic                          out_done_o
);

  logic [2:0]  b_q;
  logic        valid_q;
  logic        load, last, bit_v;
  logic [31:0] value;
  logic [csd_pkg::IdxW-1:0] idx;

  assign load  = not_empty_i && (!valid_q || m_axis_tready);
  assign last  = ({1'b0, b_q} + 4'd1) == head_i.count;
  assign pop_o = load && last;
  assign bit_v = head_i.bits[3'd7 - b_q];
  assign idx   = head_i.idx + csd_pkg::IdxW'(b_q);

  always_comb begin
    if (head_i.raw) value = head_i.fg;
    else if (head_i.kind == csd_pkg::KindMask) value = {31'b0, bit_v};
    else value = bit_v ? head_i.fg : head_i.bg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      b_q     <= '0;
    end else begin
      if (load) valid_q <= 1'b1;
      else if (m_axis_tready) valid_q <= 1'b0;
      if (load) b_q <= last ? 3'd0 : b_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_idx_o   <= idx[csd_pkg::OutIdxW-1:0];
      out_value_o <= value;
      out_kind_o  <= head_i.kind;
      out_last_o  <= last;
      out_done_o  <= head_i.done && last;
    end
  end

  assign m_axis_tvalid = valid_q;

endmodule

/* sv/cursor_shape_decoder.sv */
// Cursor shape decoder top level: byte stream in, pixel and mask words out.
//
// Takes one shape byte per cycle while the four-entry job queue has room.
// Colour bytes and partial raw-pixel bytes give no output; a complete raw
// pixel gives one word; a bitmap byte (source or mask) gives up to eight
// words, one per pixel covered. The back end emits one word per cycle while
// the output is accepted; the input stalls only when the queue fills behind
// the back end. Output words sit in a register, so the input keeps moving
// while a word waits. A zero width or height makes every byte pass without
// output. A write to any of the six defined registers restarts decoding at
// the start of a shape, as does the final mask byte.
module cursor_shape_decoder #(
  parameter int unsigned MaxCursorSide = csd_pkg::MaxCursorSideDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [csd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [csd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // data_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,  // pixel_index, item_value, zero pad
  output logic [1:0]                    m_axis_tuser,  // item_kind, shape_done
  output logic                          m_axis_tlast   // last_of_run
);

  logic          full, push, not_empty, pop;
  csd_pkg::job_t job, head;
  logic [csd_pkg::OutIdxW-1:0] out_idx;
  logic [31:0]   out_value;
  logic          out_kind, out_last, out_done;

  csd_front #(
    .MaxCursorSide(MaxCursorSide)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .queue_full_i (full),
    .push_o       (push),
    .job_o        (job)
  );

  csd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (job),
    .full_o      (full),
    .pop_i       (pop),
    .not_empty_o (not_empty),
    .head_o      (head)
  );

  csd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .not_empty_i   (not_empty),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .out_idx_o     (out_idx),
    .out_value_o   (out_value),
    .out_kind_o    (out_kind),
    .out_last_o    (out_last),
    .out_done_o    (out_done)
  );

  assign m_axis_tdata = {4'b0, out_value, out_idx};
  assign m_axis_tuser = {out_done, out_kind};
  assign m_axis_tlast = out_last;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for cursor_shape_decoder: directed table, then random cursor shapes.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxSide = csd_pkg::MaxCursorSideDefault;
  localparam int HoldOff = 64;
  localparam logic [csd_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [csd_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

  localparam logic [1:0] ChkPredict = 2'd0;
  localparam logic [1:0] ChkNone    = 2'd1;
  localparam logic [1:0] ChkOne     = 2'd2;

  localparam logic [1:0] SinkFree   = 2'd0;
  localparam logic [1:0] SinkCoin   = 2'd1;
  localparam logic [1:0] SinkSquare = 2'd2;

  typedef struct packed {
    logic                        kind;
    logic [csd_pkg::OutIdxW-1:0] idx;
    logic [31:0]                 value;
    logic                        last;
    logic                        done;
  } cursor_word_t;

  typedef struct packed {
    logic                         is_cfg;
    logic [csd_pkg::CfgIdxW-1:0]  reg_idx;
    logic [csd_pkg::CfgDataW-1:0] data;
    logic [1:0]                   check;
    cursor_word_t                 word;
  } dir_row_t;

  localparam cursor_word_t Blank = '0;
  localparam int NumRows = 28;
  localparam dir_row_t DirRows [NumRows] = '{
    '{1'b0, '0, 24'hFF, ChkNone, Blank},
    '{1'b1, csd_pkg::RegWidth, 24'd1, ChkPredict, Blank},
    '{1'b1, csd_pkg::RegHeight, 24'd1, ChkPredict, Blank},
    '{1'b0, '0, 24'h11, ChkNone, Blank},
    '{1'b0, '0, 24'h22, ChkNone, Blank},
    '{1'b0, '0, 24'h33, ChkNone, Blank},
    '{1'b0, '0, 24'h44, ChkOne, '{csd_pkg::KindSource, 12'd0, 32'h44332211, 1'b1, 1'b0}},
    '{1'b0, '0, 24'h80, ChkOne, '{csd_pkg::KindMask, 12'd0, 32'd1, 1'b1, 1'b1}},
    '{1'b1, csd_pkg::RegPixSz, 24'd0, ChkPredict, Blank},
    '{1'b0, '0, 24'hFF, ChkOne, '{csd_pkg::KindSource, 12'd0, 32'hFF, 1'b1, 1'b0}},
    '{1'b0, '0, 24'h00, ChkOne, '{csd_pkg::KindMask, 12'd0, 32'd0, 1'b1, 1'b1}},
    '{1'b1, csd_pkg::RegPixSz, 24'd1, ChkPredict, Blank},
    '{1'b0, '0, 24'h00, ChkNone, Blank},
    '{1'b0, '0, 24'hFF, ChkOne, '{csd_pkg::KindSource, 12'd0, 32'hFF00, 1'b1, 1'b0}},
    '{1'b0, '0, 24'h7F, ChkOne, '{csd_pkg::KindMask, 12'd0, 32'd0, 1'b1, 1'b1}},
    '{1'b1, csd_pkg::RegMode, 24'd1, ChkPredict, Blank},
    '{1'b1, csd_pkg::RegShifts, 24'h7FFF, ChkPredict, Blank},
    '{1'b0, '0, 24'hFF, ChkNone, Blank},
    '{1'b0, '0, 24'h00, ChkNone, Blank},
    // out-of-range index: no effect, colour bytes keep counting
    '{1'b1, RegSpareHi, 24'hFFFFFF, ChkPredict, Blank},
    '{1'b0, '0, 24'hFF, ChkNone, Blank},
    '{1'b0, '0, 24'h00, ChkNone, Blank},
    '{1'b0, '0, 24'hFF, ChkNone, Blank},
    '{1'b0, '0, 24'h55, ChkNone, Blank},
    '{1'b0, '0, 24'h80, ChkPredict, Blank},
    '{1'b0, '0, 24'h00, ChkPredict, Blank},
    '{1'b1, csd_pkg::RegMaxes, 24'h000000, ChkPredict, Blank},
    '{1'b1, RegSpareLo, 24'h000000, ChkPredict, Blank}
  };

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [csd_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [csd_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [47:0]                  m_axis_tdata;
  logic [1:0]                   m_axis_tuser;
  logic                         m_axis_tlast;

  cursor_shape_decoder dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  // decoder copy: registers and shape state
  logic [csd_pkg::SideW-1:0] reg_w = '0;
  logic [csd_pkg::SideW-1:0] reg_h = '0;
  logic                      reg_two = 1'b0;
  logic [1:0]                reg_pix = csd_pkg::PixSzReset;
  logic [23:0]               reg_max = csd_pkg::MaxesReset;
  logic [14:0]               reg_shift = csd_pkg::ShiftsReset;

  csd_pkg::phase_e ph;
  int              col_cnt, row_cnt, row_byte, pix_byte, pix_idx;
  logic [31:0]     fg_pix, bg_pix, pix_acc;

  cursor_word_t due_words[$];
  int           n_bad = 0;
  int           burst_left = 0;

  function automatic int side_of(input logic [csd_pkg::SideW-1:0] v);
    return (int'(v) > MaxSide) ? MaxSide : int'(v);
  endfunction

  function automatic int pix_bytes();
    return (reg_pix == 2'd0) ? 1 : ((reg_pix == 2'd1) ? 2 : 4);
  endfunction

  function automatic logic [31:0] pix_mask();
    return (reg_pix == 2'd0) ? 32'hFF : ((reg_pix == 2'd1) ? 32'hFFFF : 32'hFFFF_FFFF);
  endfunction

  function automatic int shape_len();
    int w, h, bpr;
    w = side_of(reg_w);
    h = side_of(reg_h);
    bpr = (w + 7) / 8;
    if (reg_two) return 6 + 2 * bpr * h;
    return w * h * pix_bytes() + bpr * h;
  endfunction

  // chan 0 red, 1 green, 2 blue
  function automatic logic [31:0] scale_chan(input logic [7:0] c, input int chan);
    logic [7:0]  mx;
    logic [4:0]  sh;
    logic [31:0] v;
    mx = reg_max[16 - 8 * chan +: 8];
    sh = reg_shift[10 - 5 * chan +: 5];
    v = (32'(c) * 32'(mx) + 32'd127) / 32'd255;
    return v << sh;
  endfunction

  task automatic restart_shape();
    ph = reg_two ? csd_pkg::PH_COLOUR : csd_pkg::PH_SOURCE;
    col_cnt = 0;
    fg_pix = '0;
    bg_pix = '0;
    row_cnt = 0;
    row_byte = 0;
    pix_acc = '0;
    pix_byte = 0;
    pix_idx = 0;
  endtask

  task automatic apply_reg(input logic [csd_pkg::CfgIdxW-1:0] idx,
                           input logic [csd_pkg::CfgDataW-1:0] val);
    case (idx)
      csd_pkg::RegWidth:  reg_w = val[6:0];
      csd_pkg::RegHeight: reg_h = val[6:0];
      csd_pkg::RegMode:   reg_two = val[0];
      csd_pkg::RegPixSz:  reg_pix = val[1:0];
      csd_pkg::RegMaxes:  reg_max = val;
      csd_pkg::RegShifts: reg_shift = val[14:0];
      default:            return;
    endcase
    restart_shape();
  endtask

  task automatic unpack_bits(input logic [7:0] b, input logic kind, output int made);
    int           w, h, bpr, col, n, k;
    logic         last_row, bitv;
    cursor_word_t wd;
    w = side_of(reg_w);
    h = side_of(reg_h);
    bpr = (w + 7) / 8;
    col = row_byte * 8;
    n = (col < w) ? w - col : 0;
    if (n > 8) n = 8;
    last_row = (row_byte + 1 == bpr) && (row_cnt + 1 == h);
    for (k = 0; k < n; k++) begin
      bitv = b[7 - k];
      wd.kind = kind;
      wd.idx = pix_idx[csd_pkg::OutIdxW-1:0];
      wd.value = (kind == csd_pkg::KindMask) ? {31'b0, bitv}
                                             : ((bitv ? fg_pix : bg_pix) & pix_mask());
      wd.last = (k + 1 == n);
      wd.done = (kind == csd_pkg::KindMask) && last_row && (k + 1 == n);
      due_words.push_back(wd);
      pix_idx++;
    end
    made = n;
    row_byte++;
    if (row_byte >= bpr) begin
      row_byte = 0;
      row_cnt++;
      if (row_cnt >= h) begin
        if (kind == csd_pkg::KindSource) begin
          ph = csd_pkg::PH_MASK;
          row_cnt = 0;
          pix_idx = 0;
        end else begin
          restart_shape();
        end
      end
    end
  endtask

  task automatic expand_byte(input logic [7:0] b, output int made);
    int           w, h;
    cursor_word_t wd;
    w = side_of(reg_w);
    h = side_of(reg_h);
    made = 0;
    if (w == 0 || h == 0) return;
    case (ph)
      csd_pkg::PH_COLOUR: begin
        if (col_cnt < 3) fg_pix |= scale_chan(b, col_cnt % 3);
        else bg_pix |= scale_chan(b, col_cnt % 3);
        col_cnt++;
        if (col_cnt >= 6) begin
          col_cnt = 0;
          ph = csd_pkg::PH_SOURCE;
        end
      end
      csd_pkg::PH_SOURCE: begin
        if (reg_two) begin
          unpack_bits(b, csd_pkg::KindSource, made);
        end else begin
          pix_acc |= 32'(b) << (8 * (pix_byte % 4));
          pix_byte++;
          if (pix_byte >= pix_bytes()) begin
            wd = '{csd_pkg::KindSource, pix_idx[csd_pkg::OutIdxW-1:0],
                   pix_acc & pix_mask(), 1'b1, 1'b0};
            due_words.push_back(wd);
            made = 1;
            pix_acc = '0;
            pix_byte = 0;
            pix_idx++;
            if (pix_idx >= w * h) begin
              ph = csd_pkg::PH_MASK;
              pix_idx = 0;
              row_cnt = 0;
              row_byte = 0;
            end
          end
        end
      end
      default: unpack_bits(b, csd_pkg::KindMask, made);
    endcase
  endtask

  // all calls start at a rising edge
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (HoldOff) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [csd_pkg::CfgIdxW-1:0] idx,
                           input logic [csd_pkg::CfgDataW-1:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, val);
  endtask

  task automatic send_byte(input logic [7:0] b, output int made);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    expand_byte(b, made);
  endtask

  logic [1:0]  sink_mode;
  logic [15:0] sink_cyc;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_mode <= SinkFree;
      sink_cyc <= '0;
    end else begin
      sink_cyc <= sink_cyc + 16'd1;
      if (sink_cyc[7:0] == 8'hFF) sink_mode <= 2'($urandom_range(0, 3));
      case (sink_mode)
        SinkFree:   m_axis_tready <= 1'b1;
        SinkCoin:   m_axis_tready <= 1'($urandom_range(0, 1));
        SinkSquare: m_axis_tready <= !sink_cyc[3];
        default:    m_axis_tready <= ($urandom_range(0, 5) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : word_check
    cursor_word_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser[0], m_axis_tdata[11:0], m_axis_tdata[43:12], m_axis_tlast,
              m_axis_tuser[1]};
      if (due_words.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected word: kind %0d idx %0d value %h last %0d done %0d",
                   got.kind, got.idx, got.value, got.last, got.done);
      end else begin
        want = due_words.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("word mismatch: exp kind %0d idx %0d value %h last %0d done %0d",
                     want.kind, want.idx, want.value, want.last, want.done);
            $display("               got kind %0d idx %0d value %h last %0d done %0d",
                     got.kind, got.idx, got.value, got.last, got.done);
          end
        end
      end
    end
  end

  initial begin
    int                           made, len, nshape, nwr, rnd_bytes, p, s, i, r;
    logic [csd_pkg::CfgIdxW-1:0]  idx;
    logic [csd_pkg::CfgDataW-1:0] data;
    rnd_bytes = 0;
    restart_shape();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NumRows; r++) begin
      if (DirRows[r].is_cfg) begin
        write_reg(DirRows[r].reg_idx, DirRows[r].data);
      end else begin
        send_byte(DirRows[r].data[7:0], made);
        if (DirRows[r].check != ChkPredict) begin
          repeat (made) void'(due_words.pop_back());
          if (DirRows[r].check == ChkOne) due_words.push_back(DirRows[r].word);
        end
      end
    end

    for (p = 0; p < 2 || rnd_bytes < 80; p++) begin
      if (p == 0) begin
        // one row of the widest shape, width above the side limit
        write_reg(csd_pkg::RegMode, 24'd1);
        write_reg(csd_pkg::RegWidth, 24'd127);
        write_reg(csd_pkg::RegHeight, 24'd1);
        write_reg(csd_pkg::RegMaxes, 24'($urandom));
        write_reg(csd_pkg::RegShifts, 24'($urandom));
      end else if (p == 1) begin
        // two bytes per row, the second one partly used
        write_reg(csd_pkg::RegWidth, 24'd10);
        write_reg(csd_pkg::RegHeight, 24'd2);
      end else begin
        nwr = $urandom_range(0, 4);
        for (i = 0; i < nwr + 2; i++) begin
          idx = (i == 0) ? csd_pkg::RegWidth
              : ((i == nwr + 1) ? csd_pkg::RegHeight : 3'($urandom_range(0, 7)));
          data = 24'($urandom);
          if (idx == csd_pkg::RegWidth || idx == csd_pkg::RegHeight)
            data[6:0] = ($urandom_range(0, 7) == 0) ? 7'd0 : 7'($urandom_range(1, 4));
          write_reg(idx, data);
        end
      end
      nshape = $urandom_range(1, 2);
      for (s = 0; s < nshape; s++) begin
        if (side_of(reg_w) == 0 || side_of(reg_h) == 0) begin
          len = $urandom_range(1, 8);
        end else begin
          len = shape_len();
          // sometimes break off the last shape; the next register write restarts it
          if (s == nshape - 1 && $urandom_range(0, 5) == 0) len = $urandom_range(0, len - 1);
        end
        rnd_bytes += len;
        for (i = 0; i < len; i++) send_byte(8'($urandom), made);
      end
    end

    wait_idle();
    if (n_bad == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* filelist.f */
sv/csd_pkg.sv
sv/csd_front.sv
sv/csd_queue.sv
sv/csd_back.sv
sv/cursor_shape_decoder.sv
verif/tb_top.sv
